// File: hw/rtl/btc_pkg.sv
package btc_pkg;

  // Field widths.
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 10;
  localparam int CH_W       = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  // Datapath widths: vertex minus pixel, one product, one cross product,
  // its magnitude, and the scaled dividend 255 * magnitude.
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int NUM_W      = MAG_W + CH_W;

  // Image sizes above this act as this.
  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(1024);

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(800);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(500);

  // Pipeline stage numbers.
  localparam int ST_DIFF  = 1;
  localparam int ST_PROD  = 2;
  localparam int ST_SUB   = 3;
  localparam int ST_MAG   = 4;
  localparam int ST_NUM   = 5;
  localparam int DIV_BITS = CH_W;
  localparam int STAGES   = ST_NUM + DIV_BITS;

  // Three vertices, three sub-triangles.
  localparam int NV = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0_X   = 3'd0,
    REG_V0_Y   = 3'd1,
    REG_V1_X   = 3'd2,
    REG_V1_Y   = 3'd3,
    REG_V2_X   = 3'd4,
    REG_V2_Y   = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } cfg_reg_t;

endpackage

// File: hw/rtl/barycentric_triangle_coverage.sv
// Barycentric triangle coverage test, one pixel per clock unless stalled.
//
// Software writes the three vertices and the image size through the cfg_
// channel (cfg_ready is always high) while the block is drained. Each
// transfer on the in_ channel carries one pixel coordinate; each transfer
// on the out_ channel returns, in order, whether that pixel is covered and
// its three barycentric weights scaled to 0..255 (all zero if uncovered).
//
// The pipeline has 13 register stages. One stage forms the
// vertex-minus-pixel differences, one the six products, one the three
// cross products, one the coverage decision and magnitudes, one the scaled
// dividends 255 * |sub|, and eight restoring-division stages each produce
// one quotient bit per channel. Throughput is one pixel per cycle while
// in_stall is low.
//
// Each stage holds its item while the stage after it is full and cannot
// move, so a stall on out_stall fills the bubbles first and reaches
// in_stall only when every stage is occupied. Nothing is dropped or
// repeated. Synchronous reset empties the pipeline and restores the
// vertices to the origin and the image to 800 by 500.
module barycentric_triangle_coverage (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [btc_pkg::PIX_W-1:0]        in_pixel_x,
  input  logic [btc_pkg::PIX_W-1:0]        in_pixel_y,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_covered,
  output logic [btc_pkg::CH_W-1:0]         out_red,
  output logic [btc_pkg::CH_W-1:0]         out_green,
  output logic [btc_pkg::CH_W-1:0]         out_blue
);

  localparam int NV       = btc_pkg::NV;
  localparam int STAGES   = btc_pkg::STAGES;
  localparam int DIV_BITS = btc_pkg::DIV_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [btc_pkg::COORD_W-1:0] vx_r [NV];
  logic [btc_pkg::COORD_W-1:0] vy_r [NV];
  logic [btc_pkg::DIM_W-1:0]   width_r;
  logic [btc_pkg::DIM_W-1:0]   height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NV; v++) begin
        vx_r[v] <= '0;
        vy_r[v] <= '0;
      end
      width_r  <= btc_pkg::WIDTH_RST;
      height_r <= btc_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (btc_pkg::cfg_reg_t'(cfg_index))
        btc_pkg::REG_V0_X:   vx_r[0]  <= cfg_data;
        btc_pkg::REG_V0_Y:   vy_r[0]  <= cfg_data;
        btc_pkg::REG_V1_X:   vx_r[1]  <= cfg_data;
        btc_pkg::REG_V1_Y:   vy_r[1]  <= cfg_data;
        btc_pkg::REG_V2_X:   vx_r[2]  <= cfg_data;
        btc_pkg::REG_V2_Y:   vy_r[2]  <= cfg_data;
        btc_pkg::REG_WIDTH:  width_r  <= cfg_data[btc_pkg::DIM_W-1:0];
        btc_pkg::REG_HEIGHT: height_r <= cfg_data[btc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image size to the largest supported dimension.
  logic [btc_pkg::DIM_W-1:0] width_eff;
  logic [btc_pkg::DIM_W-1:0] height_eff;

  assign width_eff  = (width_r  > btc_pkg::MAX_DIM) ? btc_pkg::MAX_DIM : width_r;
  assign height_eff = (height_r > btc_pkg::MAX_DIM) ? btc_pkg::MAX_DIM : height_r;

  // ---------------------------------------------------------------------
  // Triangle area, from the configuration in three register steps. The
  // user must change the configuration only while the pipeline is empty;
  // the block does not enforce it. These values then settle long before use.
  // ---------------------------------------------------------------------
  logic signed [btc_pkg::DIFF_W-1:0]  ex1, ey1, ex2, ey2;
  logic signed [btc_pkg::PROD_W-1:0]  aprod_a_r, aprod_b_r;
  logic signed [btc_pkg::CROSS_W-1:0] area_r;
  logic        [btc_pkg::CROSS_W-1:0] area_abs;
  logic        [btc_pkg::MAG_W-1:0]   area_mag_r;

  assign ex1 = {vx_r[1][btc_pkg::COORD_W-1], vx_r[1]} - {vx_r[0][btc_pkg::COORD_W-1], vx_r[0]};
  assign ey1 = {vy_r[1][btc_pkg::COORD_W-1], vy_r[1]} - {vy_r[0][btc_pkg::COORD_W-1], vy_r[0]};
  assign ex2 = {vx_r[2][btc_pkg::COORD_W-1], vx_r[2]} - {vx_r[0][btc_pkg::COORD_W-1], vx_r[0]};
  assign ey2 = {vy_r[2][btc_pkg::COORD_W-1], vy_r[2]} - {vy_r[0][btc_pkg::COORD_W-1], vy_r[0]};

  assign area_abs = area_r[btc_pkg::CROSS_W-1] ? (-area_r) : area_r;

  always_ff @(posedge clk) begin
    aprod_a_r  <= ex1 * ey2;
    aprod_b_r  <= ey1 * ex2;
    area_r     <= {aprod_a_r[btc_pkg::PROD_W-1], aprod_a_r}
                - {aprod_b_r[btc_pkg::PROD_W-1], aprod_b_r};
    area_mag_r <= area_abs[btc_pkg::MAG_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage control. A stage may load when it is empty or when the stage
  // after it moves on this cycle; the last stage moves when the receiver
  // takes the result.
  // ---------------------------------------------------------------------
  logic [STAGES:1]   vld_r;
  logic [STAGES:1]   vld_nxt;
  logic [STAGES+1:1] en;

  assign en[STAGES+1] = !out_stall;

  for (genvar g = 1; g <= STAGES; g++) begin : g_ctl
    assign en[g] = !vld_r[g] || en[g+1];
    if (g == 1) begin : g_first
      assign vld_nxt[g] = en[g] ? in_valid : vld_r[g];
    end else begin : g_rest
      assign vld_nxt[g] = en[g] ? vld_r[g-1] : vld_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !en[1];

  // ---------------------------------------------------------------------
  // Stage 1: vertex minus pixel, and the image bounds check.
  // ---------------------------------------------------------------------
  logic signed [btc_pkg::DIFF_W-1:0] dx_r [NV];
  logic signed [btc_pkg::DIFF_W-1:0] dy_r [NV];
  logic                              img1_r;

  always_ff @(posedge clk) begin
    if (en[btc_pkg::ST_DIFF]) begin
      for (int v = 0; v < NV; v++) begin
        dx_r[v] <= {vx_r[v][btc_pkg::COORD_W-1], vx_r[v]} - {3'b000, in_pixel_x};
        dy_r[v] <= {vy_r[v][btc_pkg::COORD_W-1], vy_r[v]} - {3'b000, in_pixel_y};
      end
      img1_r <= ({1'b0, in_pixel_x} < width_eff) && ({1'b0, in_pixel_y} < height_eff);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the two products of each sub-triangle's cross product.
  // Lane 0 pairs vertices 1 and 2 (red), lane 1 pairs 2 and 0 (green),
  // lane 2 pairs 0 and 1 (blue).
  // ---------------------------------------------------------------------
  logic signed [btc_pkg::PROD_W-1:0]  pa_r [NV];
  logic signed [btc_pkg::PROD_W-1:0]  pb_r [NV];
  logic                               img2_r;

  // Stage 3: the cross products.
  logic signed [btc_pkg::CROSS_W-1:0] s_r [NV];
  logic                               img3_r;

  for (genvar l = 0; l < NV; l++) begin : g_lane
    localparam int A = (l + 1) % NV;
    localparam int B = (l + 2) % NV;

    always_ff @(posedge clk) begin
      if (en[btc_pkg::ST_PROD]) begin
        pa_r[l] <= dx_r[A] * dy_r[B];
        pb_r[l] <= dy_r[A] * dx_r[B];
      end
      if (en[btc_pkg::ST_SUB]) begin
        s_r[l] <= {pa_r[l][btc_pkg::PROD_W-1], pa_r[l]}
                - {pb_r[l][btc_pkg::PROD_W-1], pb_r[l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[btc_pkg::ST_PROD]) begin
      img2_r <= img1_r;
    end
    if (en[btc_pkg::ST_SUB]) begin
      img3_r <= img2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: coverage decision and magnitudes. A sub-area of zero counts
  // on either side, so pixels on an edge are covered; all three must share
  // the sign of the whole area, whichever way the triangle winds.
  // ---------------------------------------------------------------------
  logic                               all_nonneg;
  logic                               all_nonpos;
  logic                               cov4;
  logic        [btc_pkg::CROSS_W-1:0] s_abs [NV];
  logic        [btc_pkg::MAG_W-1:0]   mag_r [NV];
  logic                               cov4_r;

  always_comb begin
    all_nonneg = 1'b1;
    all_nonpos = 1'b1;
    for (int l = 0; l < NV; l++) begin
      all_nonneg = all_nonneg && !s_r[l][btc_pkg::CROSS_W-1];
      all_nonpos = all_nonpos && (s_r[l][btc_pkg::CROSS_W-1] || (s_r[l] == '0));
      s_abs[l]   = s_r[l][btc_pkg::CROSS_W-1] ? (-s_r[l]) : s_r[l];
    end
    cov4 = img3_r && (area_r != '0)
        && (area_r[btc_pkg::CROSS_W-1] ? all_nonpos : all_nonneg);
  end

  always_ff @(posedge clk) begin
    if (en[btc_pkg::ST_MAG]) begin
      for (int l = 0; l < NV; l++) begin
        mag_r[l] <= s_abs[l][btc_pkg::MAG_W-1:0];
      end
      cov4_r <= cov4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5 and the divider. Stage 5 loads the dividend 255 * |sub|;
  // each later stage subtracts the area shifted to its quotient bit when
  // it fits. For a covered pixel |sub| <= |area|, so the quotient fits in
  // eight bits and no clamp is needed.
  // ---------------------------------------------------------------------
  logic [btc_pkg::NUM_W-1:0] rem_r [0:DIV_BITS-1][NV];
  logic [btc_pkg::CH_W-1:0]  quo_r [0:DIV_BITS][NV];
  logic                      cov_r [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (en[btc_pkg::ST_NUM]) begin
      for (int l = 0; l < NV; l++) begin
        rem_r[0][l] <= {mag_r[l], {btc_pkg::CH_W{1'b0}}}
                     - {{btc_pkg::CH_W{1'b0}}, mag_r[l]};
        quo_r[0][l] <= '0;
      end
      cov_r[0] <= cov4_r;
    end
  end

  for (genvar d = 1; d <= DIV_BITS; d++) begin : g_div
    localparam int K = DIV_BITS - d;

    logic [btc_pkg::NUM_W-1:0] dsh;
    logic                      fit [NV];

    assign dsh = {{btc_pkg::CH_W{1'b0}}, area_mag_r} << K;

    for (genvar l = 0; l < NV; l++) begin : g_dl
      assign fit[l] = rem_r[d-1][l] >= dsh;

      always_ff @(posedge clk) begin
        if (en[btc_pkg::ST_NUM + d]) begin
          quo_r[d][l] <= {quo_r[d-1][l][btc_pkg::CH_W-2:0], fit[l]};
        end
      end

      if (d < DIV_BITS) begin : g_rem
        always_ff @(posedge clk) begin
          if (en[btc_pkg::ST_NUM + d]) begin
            rem_r[d][l] <= fit[l] ? (rem_r[d-1][l] - dsh) : rem_r[d-1][l];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[btc_pkg::ST_NUM + d]) begin
        cov_r[d] <= cov_r[d-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------
  assign out_valid   = vld_r[STAGES];
  assign out_covered = cov_r[DIV_BITS];
  assign out_red     = cov_r[DIV_BITS] ? quo_r[DIV_BITS][0] : '0;
  assign out_green   = cov_r[DIV_BITS] ? quo_r[DIV_BITS][1] : '0;
  assign out_blue    = cov_r[DIV_BITS] ? quo_r[DIV_BITS][2] : '0;

endmodule

// File: hw/rtl/btc_checker.sv
module btc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_covered,
  input logic [btc_pkg::CH_W-1:0] out_red,
  input logic [btc_pkg::CH_W-1:0] out_green,
  input logic [btc_pkg::CH_W-1:0] out_blue
);

  logic [btc_pkg::CH_W+1:0] wsum;

  assign wsum = {2'b00, out_red} + {2'b00, out_green} + {2'b00, out_blue};

  // The pipeline is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_covered)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  // Back pressure only reaches the input once a result waits at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  // An uncovered pixel carries zero weights.
  a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("uncovered pixel with nonzero weights");

  // The three truncated weights of a covered pixel sum to 253..255.
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> wsum <= 10'd255 && wsum >= 10'd253)
    else $error("weights of a covered pixel do not sum to about 255");

endmodule

bind barycentric_triangle_coverage btc_checker u_btc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_covered (out_covered),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue)
);

// File: bench/tb_barycentric_triangle_coverage.sv
`timescale 1ns / 100ps

module tb_barycentric_triangle_coverage;

  localparam int PIX_W      = btc_pkg::PIX_W;
  localparam int CH_W       = btc_pkg::CH_W;
  localparam int CFG_IDX_W  = btc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = btc_pkg::CFG_DATA_W;
  localparam int COORD_W    = btc_pkg::COORD_W;
  localparam int DIM_W      = btc_pkg::DIM_W;
  localparam int NV         = btc_pkg::NV;

  localparam int RESET_CYCLES = 11;
  // The pipeline is 13 stages deep, so this is plenty to catch a stray result.
  localparam int DRAIN_CYCLES = 30;
  // A slow run is roughly 2000 pixels times (idle gap + stall + latency),
  // plus the register writes. This limit is several times that.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PIX_MAX      = (1 << PIX_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic            covered;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } shade_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_x = '0;
  logic [PIX_W-1:0]      in_pixel_y = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic                  out_covered;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;

  barycentric_triangle_coverage DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_covered (out_covered),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // This is the bench's copy of the configuration registers, starting at
  // their reset values. The copy changes only when a register write is
  // accepted, and that happens only while the block is drained.
  logic signed [COORD_W-1:0] vtx_x [NV] = '{default: '0};
  logic signed [COORD_W-1:0] vtx_y [NV] = '{default: '0};
  logic [DIM_W-1:0]          img_w = btc_pkg::WIDTH_RST;
  logic [DIM_W-1:0]          img_h = btc_pkg::HEIGHT_RST;

  pixel_t pending_pixels [$];   // queued for the driver, not yet transferred
  shade_t expected_shades [$];  // scored on input, awaiting the output

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int send_gap     = 0;
  int stall_left   = 0;
  bit pixel_accepted = 1'b0;

  int cycle_count   = 0;
  int error_count   = 0;
  int result_count  = 0;
  int covered_count = 0;
  int phase_count   = 0;

  // ---------------------------------------------------------------------
  // Predictor. Every cross product is twice a signed area and exact in
  // 64-bit integers. The weights are ratios of those areas, so the 1/2
  // factors cancel and no fractional arithmetic is needed.
  // ---------------------------------------------------------------------
  function automatic longint cross2(input longint ax, ay, bx, by);
    return ax * by - ay * bx;
  endfunction

  // This computes floor(255 * |part| / |whole|). A zero area gives zero,
  // although such a pixel is never covered in the first place.
  function automatic logic [CH_W-1:0] scale_weight(input longint part, whole);
    longint num, den, q;
    num = (part < 0) ? -part : part;
    den = (whole < 0) ? -whole : whole;
    if (den == 0) return '0;
    q = (255 * num) / den;
    if (q > 255) return 8'd255;
    return q[CH_W-1:0];
  endfunction

  function automatic shade_t shade_pixel(input logic [PIX_W-1:0] px_in, py_in);
    longint px, py, w, h, area, s0, s1, s2;
    longint vx [NV];
    longint vy [NV];
    bit hit;
    shade_t r;
    px = px_in;
    py = py_in;
    for (int i = 0; i < NV; i++) begin
      vx[i] = vtx_x[i];
      vy[i] = vtx_y[i];
    end
    // A width or height above the largest image is treated as the largest.
    w = (img_w > btc_pkg::MAX_DIM) ? btc_pkg::MAX_DIM : img_w;
    h = (img_h > btc_pkg::MAX_DIM) ? btc_pkg::MAX_DIM : img_h;
    area = cross2(vx[1] - vx[0], vy[1] - vy[0], vx[2] - vx[0], vy[2] - vy[0]);
    s0 = cross2(vx[1] - px, vy[1] - py, vx[2] - px, vy[2] - py);
    s1 = cross2(vx[2] - px, vy[2] - py, vx[0] - px, vy[0] - py);
    s2 = cross2(vx[0] - px, vy[0] - py, vx[1] - px, vy[1] - py);
    // A degenerate triangle, with zero area, covers nothing. On either
    // winding, the sub-areas must match the sign of the total area. A zero
    // sub-area (pixel on an edge or a vertex) still counts as inside.
    hit = (px < w) && (py < h) && (area != 0);
    if (hit) begin
      if (area > 0) hit = (s0 >= 0) && (s1 >= 0) && (s2 >= 0);
      else          hit = (s0 <= 0) && (s1 <= 0) && (s2 <= 0);
    end
    r = '0;
    if (hit) begin
      r.covered = 1'b1;
      r.red     = scale_weight(s0, area);
      r.green   = scale_weight(s1, area);
      r.blue    = scale_weight(s2, area);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Pixel driver. Inputs change on the falling edge. A stalled pixel is
  // held unchanged. Otherwise the next queued pixel is presented, unless
  // an idle burst is running.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (send_gap != 0) send_gap--;
    if (!(in_valid && !pixel_accepted)) begin
      if (send_gap == 0 && send_idle_on && $urandom_range(0, 9) == 0)
        send_gap = $urandom_range(1, 13);
      if (send_gap == 0 && pending_pixels.size() != 0) begin
        in_valid   <= 1'b1;
        in_pixel_x <= pending_pixels[0].x;
        in_pixel_y <= pending_pixels[0].y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge, using the
  // values that held just before the edge. A pixel is scored when its
  // transfer happens, and each result is checked against the oldest score.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    shade_t want;
    pixel_accepted = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_shades.push_back(shade_pixel(in_pixel_x, in_pixel_y));
        void'(pending_pixels.pop_front());
        pixel_accepted = 1'b1;
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_shades.size() == 0) begin
          $error("result transfer with no pixel outstanding");
          error_count++;
        end else begin
          want = expected_shades.pop_front();
          if (want.covered) covered_count++;
          check_field("covered", want.covered, out_covered);
          check_field("red",     want.red,     out_red);
          check_field("green",   want.green,   out_green);
          check_field("blue",    want.blue,    out_blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results outstanding",
             cycle_count, expected_shades.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic write_reg(input btc_pkg::cfg_reg_t idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      btc_pkg::REG_V0_X:   vtx_x[0] = data;
      btc_pkg::REG_V0_Y:   vtx_y[0] = data;
      btc_pkg::REG_V1_X:   vtx_x[1] = data;
      btc_pkg::REG_V1_Y:   vtx_y[1] = data;
      btc_pkg::REG_V2_X:   vtx_x[2] = data;
      btc_pkg::REG_V2_Y:   vtx_y[2] = data;
      btc_pkg::REG_WIDTH:  img_w = data[DIM_W-1:0];
      btc_pkg::REG_HEIGHT: img_h = data[DIM_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The width and height values are passed as full 12-bit data. Any bit
  // above the 11-bit register is dropped by the block.
  task automatic load_triangle(input int x0, y0, x1, y1, x2, y2, w, h);
    write_reg(btc_pkg::REG_V0_X,   CFG_DATA_W'(x0));
    write_reg(btc_pkg::REG_V0_Y,   CFG_DATA_W'(y0));
    write_reg(btc_pkg::REG_V1_X,   CFG_DATA_W'(x1));
    write_reg(btc_pkg::REG_V1_Y,   CFG_DATA_W'(y1));
    write_reg(btc_pkg::REG_V2_X,   CFG_DATA_W'(x2));
    write_reg(btc_pkg::REG_V2_Y,   CFG_DATA_W'(y2));
    write_reg(btc_pkg::REG_WIDTH,  CFG_DATA_W'(w));
    write_reg(btc_pkg::REG_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic add_pixel(input int x, y);
    pixel_t p;
    p.x = PIX_W'(x);
    p.y = PIX_W'(y);
    pending_pixels.push_back(p);
  endtask

  // The sender holds off here until every result has come back. Every
  // pixel yields exactly one result, so the block is then idle and the
  // registers may be rewritten.
  task automatic finish_phase();
    while (pending_pixels.size() != 0 || expected_shades.size() != 0)
      @(posedge clk);
    phase_count++;
  endtask

  function automatic int rand_between(input int lo, hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_pixel(input int v);
    return (v < 0) ? 0 : (v > PIX_MAX) ? PIX_MAX : v;
  endfunction

  // Image sizes are mostly legal. Sometimes a size is zero, one, at the
  // limit, just past the limit, the register maximum, or any 12-bit value.
  function automatic int pick_dimension();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0:       return 0;
        1:       return 1;
        2:       return 1024;
        3:       return 1025;
        default: return 2047;
      endcase
    end
    if (sel == 1) return $urandom_range(0, 4095);
    return rand_between(1, 1024);
  endfunction

  // One random setting followed by a burst of pixels. Most pixels fall
  // inside the triangle's bounding box, so that coverage, edges and weights
  // get real exercise. The rest fall anywhere in the 10-bit space.
  task automatic random_phase(input int n, input bit quiet);
    int vx [NV];
    int vy [NV];
    int lo_x, hi_x, lo_y, hi_y, dx, dy;
    case ($urandom_range(0, 9))
      0: begin
        for (int i = 0; i < NV; i++) begin
          vx[i] = rand_between(-2048, 2047);
          vy[i] = rand_between(-2048, 2047);
        end
      end
      1: begin
        // Collinear or coincident vertices give zero area.
        vx[0] = rand_between(-500, 500);
        vy[0] = rand_between(-500, 500);
        dx = rand_between(-300, 300);
        dy = rand_between(-300, 300);
        vx[1] = vx[0] + dx;
        vy[1] = vy[0] + dy;
        vx[2] = vx[0] + 2 * dx;
        vy[2] = vy[0] + 2 * dy;
      end
      2: begin
        vx[0] = rand_between(0, 1023);
        vy[0] = rand_between(0, 1023);
        for (int i = 1; i < NV; i++) begin
          vx[i] = vx[0] + rand_between(-20, 20);
          vy[i] = vy[0] + rand_between(-20, 20);
        end
      end
      3: begin
        // With axis-aligned legs, many pixels fall exactly on an edge.
        vx[0] = rand_between(0, 900);
        vy[0] = rand_between(0, 900);
        vx[1] = vx[0] + rand_between(-300, 300);
        vy[1] = vy[0];
        vx[2] = vx[0];
        vy[2] = vy[0] + rand_between(-300, 300);
      end
      default: begin
        for (int i = 0; i < NV; i++) begin
          vx[i] = rand_between(-200, 1223);
          vy[i] = rand_between(-200, 1223);
        end
      end
    endcase
    load_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2],
                  pick_dimension(), pick_dimension());

    lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
    for (int i = 1; i < NV; i++) begin
      if (vx[i] < lo_x) lo_x = vx[i];
      if (vx[i] > hi_x) hi_x = vx[i];
      if (vy[i] < lo_y) lo_y = vy[i];
      if (vy[i] > hi_y) hi_y = vy[i];
    end
    lo_x = clamp_pixel(lo_x); hi_x = clamp_pixel(hi_x);
    lo_y = clamp_pixel(lo_y); hi_y = clamp_pixel(hi_y);

    send_idle_on = !quiet && ($urandom_range(0, 3) != 0);
    recv_idle_on = !quiet && ($urandom_range(0, 3) != 0);
    if (quiet) begin
      send_gap   = 0;
      stall_left = 0;
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) != 0)
        add_pixel(rand_between(lo_x, hi_x), rand_between(lo_y, hi_y));
      else
        add_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
    end
    finish_phase();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset all three vertices sit at the origin, so nothing is covered.
    add_pixel(0, 0);
    add_pixel(PIX_MAX, PIX_MAX);
    add_pixel(3, 7);
    finish_phase();

    // This triangle winds counter-clockwise. The pixels test the vertices,
    // the hypotenuse, the interior and points just outside.
    load_triangle(0, 0, 100, 0, 0, 100, 1024, 1024);
    add_pixel(0, 0);
    add_pixel(100, 0);
    add_pixel(0, 100);
    add_pixel(50, 50);
    add_pixel(10, 10);
    add_pixel(33, 33);
    add_pixel(101, 0);
    add_pixel(51, 50);
    finish_phase();

    // This is the same triangle with the opposite winding.
    load_triangle(0, 0, 0, 100, 100, 0, 1024, 1024);
    add_pixel(10, 10);
    add_pixel(50, 50);
    add_pixel(0, 0);
    add_pixel(60, 60);
    finish_phase();

    // Vertices at the coordinate extremes. The image size is larger than
    // the limit, so it acts as the limit.
    load_triangle(-2048, -2048, 2047, -2048, 2047, 2047, 2047, 1025);
    add_pixel(PIX_MAX, 0);
    add_pixel(PIX_MAX, PIX_MAX);
    add_pixel(0, PIX_MAX);
    finish_phase();

    // A zero image width or height covers nothing. A 1 by 1 image allows
    // only the origin.
    load_triangle(0, 0, 1023, 0, 0, 1023, 0, 1024);
    add_pixel(0, 0);
    finish_phase();
    write_reg(btc_pkg::REG_WIDTH, CFG_DATA_W'(1));
    write_reg(btc_pkg::REG_HEIGHT, '0);
    add_pixel(0, 0);
    finish_phase();
    write_reg(btc_pkg::REG_HEIGHT, CFG_DATA_W'(1));
    add_pixel(0, 0);
    add_pixel(1, 0);
    add_pixel(0, 1);
    finish_phase();

    for (int p = 0; p < 17; p++)
      random_phase(rand_between(90, 130), 1'b0);
    // The last stretch runs with no idle cycles on either side.
    random_phase(150, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d pixel results across %0d register settings; %0d were covered.",
             result_count, phase_count, covered_count);
    $display("The settings included degenerate, extreme, tiny and axis-aligned triangles.");
    if (error_count == 0 && expected_shades.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
